@@ design/icpu_pkg.sv @@
// Shared types and constants for the intcode step machine.
// Used by the controller, the datapath, the top level and the checker.
package icpu_pkg;

   localparam int WORD_W     = 64;
   localparam int ADDR_W     = 12;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 72;

   // item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_PUSH  = 2'd1;
   localparam logic [1:0] KIND_EXEC  = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   // opcodes
   localparam logic [6:0] OP_ADD  = 7'd1;
   localparam logic [6:0] OP_MUL  = 7'd2;
   localparam logic [6:0] OP_IN   = 7'd3;
   localparam logic [6:0] OP_OUT  = 7'd4;
   localparam logic [6:0] OP_JT   = 7'd5;
   localparam logic [6:0] OP_JF   = 7'd6;
   localparam logic [6:0] OP_LT   = 7'd7;
   localparam logic [6:0] OP_EQ   = 7'd8;
   localparam logic [6:0] OP_ARB  = 7'd9;
   localparam logic [6:0] OP_HALT = 7'd99;

   // parameter modes; MODE_BAD stands for any digit above two
   localparam logic [1:0] MODE_POS = 2'd0;
   localparam logic [1:0] MODE_IMM = 2'd1;
   localparam logic [1:0] MODE_REL = 2'd2;
   localparam logic [1:0] MODE_BAD = 2'd3;

   localparam int DEC_DIV = 10000;

   typedef enum logic [1:0] {
      ST_RUN   = 2'd0,
      ST_WAIT  = 2'd1,
      ST_HALT  = 2'd2,
      ST_FAULT = 2'd3
   } run_state_type;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_CAPTURE,
      DP_CLR_INIT,
      DP_CLR_STEP,
      DP_LOAD,
      DP_PUSH,
      DP_FETCH,
      DP_FLATCH,
      DP_DEC_STEP,
      DP_DEC_A,
      DP_DEC_B,
      DP_PARAM,
      DP_PWAIT,
      DP_RDA,
      DP_RDAW,
      DP_RDBW,
      DP_EXEC,
      DP_MUL,
      DP_WRITE,
      DP_INW,
      DP_ADV_INIT,
      DP_ADV_STEP,
      DP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      set_fault;
      logic      set_halt;
      logic      set_wait;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       running;
      logic       cw_zero;
      logic       dec_last;
      logic       is_halt;
      logic [1:0] np;
      logic       p_fault;
      logic       p_imm;
      logic       eff_bad;
      logic       p_last;
      logic       op_arith;
      logic       op_mul;
      logic       op_input;
      logic       fifo_empty;
      logic       jump_taken;
      logic       jump_bad;
      logic       mul_last;
      logic       ext_zero;
      logic       adv_last;
      logic       clr_last;
   } stat_type;

endpackage

@@ design/icpu_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module icpu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                                          clock,
   input  logic                                          en,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
   input  logic [WIDTH-1:0]                              wdata,
   output logic [WIDTH-1:0]                              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata <= mem[addr];
      end
   end
endmodule

@@ design/icpu_ctrl.sv @@
// Sequencer for the intcode step machine: one item at a time.
// Depends on icpu_pkg; drives icpu_dpath through cmd_type, reads stat_type.
module icpu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  icpu_pkg::stat_type stat,
   output icpu_pkg::cmd_type  cmd
);
   import icpu_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_LOAD, S_PUSH, S_CLRI,
      S_FETCH, S_FLATCH, S_DEC, S_DECA, S_DECB, S_OPCHK,
      S_PARAM, S_PWAIT, S_RDA, S_RDAW, S_RDBW, S_EXEC,
      S_MUL, S_WRITE, S_INW, S_ADVI, S_ADVS, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rdy_ff;
   logic      rsp_valid_ff;
   logic      clr_item_ff;

   always_comb begin
      state_in      = state_ff;
      cmd.op        = DP_NONE;
      cmd.set_fault = 1'b0;
      cmd.set_halt  = 1'b0;
      cmd.set_wait  = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = DP_CLR_STEP;
            if (stat.clr_last) state_in = clr_item_ff ? S_DONE : S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && rdy_ff) begin
               cmd.op   = DP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.kind)
               KIND_LOAD:  state_in = S_LOAD;
               KIND_PUSH:  state_in = S_PUSH;
               KIND_EXEC:  state_in = stat.running ? S_FETCH : S_DONE;
               KIND_CLEAR: state_in = S_CLRI;
            endcase
         end
         S_LOAD: begin
            cmd.op   = DP_LOAD;
            state_in = S_DONE;
         end
         S_PUSH: begin
            cmd.op   = DP_PUSH;
            state_in = S_DONE;
         end
         S_CLRI: begin
            cmd.op   = DP_CLR_INIT;
            state_in = S_CLEAR;
         end
         S_FETCH: begin
            cmd.op   = DP_FETCH;
            state_in = S_FLATCH;
         end
         S_FLATCH: begin
            cmd.op   = DP_FLATCH;
            state_in = S_DEC;
         end
         S_DEC: begin
            if (stat.cw_zero) begin
               cmd.set_fault = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.op = DP_DEC_STEP;
               if (stat.dec_last) state_in = S_DECA;
            end
         end
         S_DECA: begin
            cmd.op   = DP_DEC_A;
            state_in = S_DECB;
         end
         S_DECB: begin
            cmd.op   = DP_DEC_B;
            state_in = S_OPCHK;
         end
         S_OPCHK: begin
            priority if (stat.is_halt) begin
               cmd.set_halt = 1'b1;
               state_in     = S_DONE;
            end else if (stat.np == 2'd0) begin
               state_in = S_ADVI;
            end else begin
               state_in = S_PARAM;
            end
         end
         S_PARAM: begin
            priority if (stat.p_fault) begin
               cmd.set_fault = 1'b1;
               state_in      = S_DONE;
            end else if (stat.p_imm) begin
               cmd.op   = DP_PARAM;
               state_in = stat.p_last ? S_RDA : S_PARAM;
            end else begin
               cmd.op   = DP_PARAM;
               state_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            if (stat.eff_bad) begin
               cmd.set_fault = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.op   = DP_PWAIT;
               state_in = stat.p_last ? S_RDA : S_PARAM;
            end
         end
         S_RDA: begin
            cmd.op   = DP_RDA;
            state_in = S_RDAW;
         end
         S_RDAW: begin
            cmd.op   = DP_RDAW;
            state_in = (stat.np >= 2'd2) ? S_RDBW : S_EXEC;
         end
         S_RDBW: begin
            cmd.op   = DP_RDBW;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            priority if (stat.op_input && stat.fifo_empty) begin
               cmd.set_wait = 1'b1;
               state_in     = S_DONE;
            end else if (stat.jump_taken && stat.jump_bad) begin
               cmd.set_fault = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.op = DP_EXEC;
               priority if (stat.op_arith)   state_in = S_WRITE;
               else if (stat.op_mul)         state_in = S_MUL;
               else if (stat.op_input)       state_in = S_INW;
               else if (stat.jump_taken)     state_in = S_DONE;
               else                          state_in = S_ADVI;
            end
         end
         S_MUL: begin
            cmd.op = DP_MUL;
            if (stat.mul_last) state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.op   = DP_WRITE;
            state_in = S_ADVI;
         end
         S_INW: begin
            cmd.op   = DP_INW;
            state_in = S_ADVI;
         end
         S_ADVI: begin
            cmd.op   = DP_ADV_INIT;
            state_in = stat.ext_zero ? S_DONE : S_ADVS;
         end
         S_ADVS: begin
            cmd.op = DP_ADV_STEP;
            if (stat.adv_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = DP_RESP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rdy_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_item_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdy_ff   <= (state_in == S_IDLE);
         if (cmd.op == DP_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op == DP_CLR_INIT) begin
            clr_item_ff <= 1'b1;
         end else if (state_ff == S_IDLE) begin
            clr_item_ff <= 1'b0;
         end
      end
   end

   assign req_tready = rdy_ff;
   assign rsp_tvalid = rsp_valid_ff;
endmodule

@@ design/icpu_dpath.sv @@
// Datapath of the intcode step machine: word store, input FIFO, decoder,
// address resolution, ALU with shared 32x32 multiplier, PC wrap divider.
// Depends on icpu_pkg and icpu_ram; steered by icpu_ctrl.
module icpu_dpath #(
   parameter int MEM_WORDS = 4096,
   parameter int IN_DEPTH  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  icpu_pkg::cmd_type                cmd,
   output icpu_pkg::stat_type               stat,
   input  logic [1:0]                       req_kind,
   input  logic [icpu_pkg::ADDR_W-1:0]      req_address,
   input  logic [icpu_pkg::WORD_W-1:0]      req_value,
   output logic [icpu_pkg::RSP_DATA_W-1:0]  rsp_data,
   output logic                             rsp_out_valid
);
   import icpu_pkg::*;

   localparam int AW  = $clog2(MEM_WORDS);
   localparam int EW  = $clog2(MEM_WORDS + 1);
   localparam int NXW = AW + 1;
   localparam int DCW = $clog2(AW + 2);
   localparam int FPW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
   localparam int CW  = $clog2(IN_DEPTH + 1);
   localparam logic [WORD_W-1:0] MEM_LIM   = WORD_W'(MEM_WORDS);
   localparam logic [CW-1:0]     FIFO_FULL = CW'(IN_DEPTH);
   localparam logic [FPW-1:0]    FIFO_LAST = FPW'(IN_DEPTH - 1);

   // captured item
   logic [1:0]        kind_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [WORD_W-1:0] val_ff;

   // architectural state
   logic [AW-1:0]     pc_ff;
   logic [WORD_W-1:0] rb_ff;
   run_state_type     run_ff;
   logic [EW-1:0]     ext_ff;
   logic [FPW-1:0]    head_ff, tail_ff;
   logic [CW-1:0]     cnt_ff;
   logic [AW-1:0]     clr_ff;

   // instruction work registers
   logic [WORD_W-1:0] cw_ff, cw_sh_ff;
   logic [13:0]       modr_ff;
   logic [3:0]        dec_cnt_ff;
   logic [6:0]        q100_ff;
   logic [3:0]        q1000_ff;
   logic [6:0]        op_ff;
   logic [1:0]        mode_ff [1:3];
   logic [1:0]        np_ff;
   logic [1:0]        k_ff;
   logic [AW-1:0]     ad_ff [1:3];
   logic [WORD_W-1:0] a_ff, b_ff, res_ff;
   logic [1:0]        mul_cnt_ff;
   logic [NXW-1:0]    dvd_ff;
   logic [EW-1:0]     rem_ff;
   logic [DCW-1:0]    div_cnt_ff;

   // per-item result and output register
   logic              ov_ff, drop_ff;
   logic [WORD_W-1:0] oval_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_ov_ff, rsp_drop_ff;
   logic [WORD_W-1:0] rsp_oval_ff;

   // memories
   logic              mem_en, mem_we;
   logic [AW-1:0]     mem_addr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;
   logic              fifo_en, fifo_we;
   logic [FPW-1:0]    fifo_addr;
   logic [WORD_W-1:0] fifo_rdata;

   icpu_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_word_ram (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   icpu_ram #(.WIDTH(WORD_W), .DEPTH(IN_DEPTH)) u_fifo_ram (
      .clock (clock),
      .en    (fifo_en),
      .we    (fifo_we),
      .addr  (fifo_addr),
      .wdata (val_ff),
      .rdata (fifo_rdata)
   );

   // combinational helpers
   logic [NXW-1:0]    raw;
   logic [1:0]        mode_k;
   logic              load_ok;
   logic [WORD_W-1:0] rel_sum;
   logic              eff_bad;
   logic [AW-1:0]     eff_addr;
   logic [17:0]       dec_rp;
   logic [3:0]        dec_q;
   logic [6:0]        op_dec;
   logic [3:0]        q10;
   logic [3:0]        m1_dig;
   logic [1:0]        m3_code;
   logic [1:0]        np_dec;
   logic              jump_cond;
   logic [31:0]       mul_x, mul_y;
   logic [WORD_W-1:0] mul_p;
   logic [2:0]        len;
   logic [NXW-1:0]    nxt;
   logic [EW:0]       div_t;
   logic              fifo_full;

   function automatic logic [1:0] mode_of(input logic [3:0] d);
      return (d < 4'd3) ? d[1:0] : MODE_BAD;
   endfunction

   always_comb begin
      raw      = {1'b0, pc_ff} + NXW'(k_ff);
      mode_k   = mode_ff[k_ff];
      load_ok  = 32'(addr_ff) < 32'(MEM_WORDS);
      rel_sum  = rb_ff + mem_rdata;
      if (mode_k == MODE_POS) begin
         eff_bad  = mem_rdata >= MEM_LIM;
         eff_addr = mem_rdata[AW-1:0];
      end else begin
         eff_bad  = (mem_rdata[WORD_W-1] && rb_ff[WORD_W-1]) || (rel_sum >= MEM_LIM);
         eff_addr = rel_sum[AW-1:0];
      end

      // remainder by ten thousand, one nibble a step
      dec_rp = {modr_ff, cw_sh_ff[WORD_W-1 -: 4]};
      dec_q  = 4'd0;
      for (int k = 1; k < 16; k++) begin
         if (dec_rp >= 18'(k * DEC_DIV)) dec_q = 4'(k);
      end

      op_dec = 7'(modr_ff - 14'(q100_ff) * 14'd100);
      if (cw_ff[WORD_W-1]) op_dec = 7'd0;
      q10 = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (q100_ff >= 7'(k * 10)) q10 = 4'(k);
      end
      m1_dig = 4'(q100_ff - 7'(q10) * 7'd10);
      priority if (cw_ff < 64'd10000) m3_code = MODE_POS;
      else if (cw_ff < 64'd20000)     m3_code = MODE_IMM;
      else if (cw_ff < 64'd30000)     m3_code = MODE_REL;
      else                            m3_code = MODE_BAD;
      unique case (op_dec)
         OP_ADD, OP_MUL, OP_LT, OP_EQ: np_dec = 2'd3;
         OP_JT, OP_JF:                 np_dec = 2'd2;
         OP_IN, OP_OUT, OP_ARB:        np_dec = 2'd1;
         default:                      np_dec = 2'd0;
      endcase

      jump_cond = (op_ff == OP_JT) == (a_ff != '0);

      unique case (mul_cnt_ff)
         2'd0:    begin mul_x = a_ff[31:0];  mul_y = b_ff[31:0];  end
         2'd1:    begin mul_x = a_ff[31:0];  mul_y = b_ff[63:32]; end
         default: begin mul_x = a_ff[63:32]; mul_y = b_ff[31:0];  end
      endcase
      mul_p = WORD_W'(mul_x) * WORD_W'(mul_y);

      len   = (np_ff == 2'd0) ? 3'd2 : 3'(np_ff) + 3'd1;
      nxt   = {1'b0, pc_ff} + NXW'(len);
      div_t = {rem_ff, dvd_ff[NXW-1]};
      if (div_t >= {1'b0, ext_ff}) div_t = div_t - {1'b0, ext_ff};

      fifo_full = cnt_ff == FIFO_FULL;
   end

   // memory port steering
   always_comb begin
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = pc_ff;
      mem_wdata = res_ff;
      fifo_en   = 1'b0;
      fifo_we   = 1'b0;
      fifo_addr = head_ff;
      unique case (cmd.op)
         DP_CLR_STEP: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = clr_ff; mem_wdata = '0;
         end
         DP_LOAD: begin
            mem_en = load_ok; mem_we = load_ok; mem_addr = AW'(addr_ff); mem_wdata = val_ff;
         end
         DP_FETCH: mem_en = 1'b1;
         DP_PARAM: begin
            mem_en = 1'b1; mem_addr = raw[AW-1:0];
         end
         DP_RDA: begin
            mem_en = 1'b1; mem_addr = ad_ff[1];
         end
         DP_RDAW: begin
            mem_en = 1'b1; mem_addr = ad_ff[2];
         end
         DP_WRITE: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = ad_ff[3];
         end
         DP_INW: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = ad_ff[1]; mem_wdata = fifo_rdata;
         end
         DP_PUSH: begin
            fifo_en = !fifo_full; fifo_we = !fifo_full; fifo_addr = tail_ff;
         end
         DP_EXEC: fifo_en = (op_ff == OP_IN) && (cnt_ff != '0);
         default: ;
      endcase
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         rb_ff   <= '0;
         run_ff  <= ST_RUN;
         ext_ff  <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
         clr_ff  <= '0;
      end else begin
         if (mem_we && (cmd.op != DP_CLR_STEP) && (EW'(mem_addr) + EW'(1) > ext_ff)) begin
            ext_ff <= EW'(mem_addr) + EW'(1);
         end
         priority if (cmd.op == DP_CLR_INIT) run_ff <= ST_RUN;
         else if (cmd.set_fault)             run_ff <= ST_FAULT;
         else if (cmd.set_halt)              run_ff <= ST_HALT;
         else if (cmd.set_wait)              run_ff <= ST_WAIT;
         else if (cmd.op == DP_PUSH && !fifo_full && run_ff == ST_WAIT) run_ff <= ST_RUN;
         else                                run_ff <= run_ff;
         unique case (cmd.op)
            DP_CLR_INIT: begin
               pc_ff   <= '0;
               rb_ff   <= '0;
               ext_ff  <= '0;
               head_ff <= '0;
               tail_ff <= '0;
               cnt_ff  <= '0;
               clr_ff  <= '0;
            end
            DP_CLR_STEP: clr_ff <= (clr_ff == AW'(MEM_WORDS - 1)) ? '0 : clr_ff + AW'(1);
            DP_PUSH: begin
               if (!fifo_full) begin
                  tail_ff <= (tail_ff == FIFO_LAST) ? '0 : tail_ff + FPW'(1);
                  cnt_ff  <= cnt_ff + CW'(1);
               end
            end
            DP_INW: begin
               head_ff <= (head_ff == FIFO_LAST) ? '0 : head_ff + FPW'(1);
               cnt_ff  <= cnt_ff - CW'(1);
            end
            DP_EXEC: begin
               if (op_ff == OP_ARB) rb_ff <= rb_ff + a_ff;
               if ((op_ff == OP_JT || op_ff == OP_JF) && jump_cond) pc_ff <= b_ff[AW-1:0];
            end
            DP_ADV_INIT: if (ext_ff == '0) pc_ff <= '0;
            DP_ADV_STEP: if (div_cnt_ff == DCW'(1)) pc_ff <= AW'(div_t);
            default: ;
         endcase
      end
   end

   // work and payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_CAPTURE: begin
            kind_ff <= req_kind;
            addr_ff <= req_address;
            val_ff  <= req_value;
            ov_ff   <= 1'b0;
            oval_ff <= '0;
            drop_ff <= 1'b0;
         end
         DP_PUSH: drop_ff <= fifo_full;
         DP_FLATCH: begin
            cw_ff      <= mem_rdata;
            cw_sh_ff   <= mem_rdata;
            modr_ff    <= '0;
            dec_cnt_ff <= '0;
         end
         DP_DEC_STEP: begin
            modr_ff    <= 14'(dec_rp - 18'(dec_q) * 18'(DEC_DIV));
            cw_sh_ff   <= {cw_sh_ff[WORD_W-5:0], 4'd0};
            dec_cnt_ff <= dec_cnt_ff + 4'd1;
         end
         DP_DEC_A: begin
            q100_ff  <= 7'((28'(modr_ff) * 28'd5243) >> 19);
            q1000_ff <= 4'((28'(modr_ff) * 28'd8389) >> 23);
         end
         DP_DEC_B: begin
            op_ff      <= op_dec;
            np_ff      <= np_dec;
            mode_ff[1] <= mode_of(m1_dig);
            mode_ff[2] <= mode_of(q1000_ff);
            mode_ff[3] <= m3_code;
            k_ff       <= 2'd1;
         end
         DP_PARAM: begin
            if (mode_k == MODE_IMM) begin
               ad_ff[k_ff] <= raw[AW-1:0];
               k_ff        <= k_ff + 2'd1;
            end
         end
         DP_PWAIT: begin
            ad_ff[k_ff] <= eff_addr;
            k_ff        <= k_ff + 2'd1;
         end
         DP_RDAW: a_ff <= mem_rdata;
         DP_RDBW: b_ff <= mem_rdata;
         DP_EXEC: begin
            mul_cnt_ff <= 2'd0;
            unique case (op_ff)
               OP_ADD: res_ff <= a_ff + b_ff;
               OP_LT:  res_ff <= ($signed(a_ff) < $signed(b_ff)) ? WORD_W'(1) : '0;
               OP_EQ:  res_ff <= (a_ff == b_ff) ? WORD_W'(1) : '0;
               OP_OUT: begin
                  ov_ff   <= 1'b1;
                  oval_ff <= a_ff;
               end
               default: ;
            endcase
         end
         DP_MUL: begin
            mul_cnt_ff <= mul_cnt_ff + 2'd1;
            if (mul_cnt_ff == 2'd0) res_ff <= mul_p;
            else                    res_ff <= res_ff + {mul_p[31:0], 32'd0};
         end
         DP_ADV_INIT: begin
            dvd_ff     <= nxt;
            rem_ff     <= '0;
            div_cnt_ff <= DCW'(NXW);
         end
         DP_ADV_STEP: begin
            rem_ff     <= EW'(div_t);
            dvd_ff     <= {dvd_ff[NXW-2:0], 1'b0};
            div_cnt_ff <= div_cnt_ff - DCW'(1);
         end
         DP_RESP: begin
            rsp_status_ff <= run_ff;
            rsp_ov_ff     <= ov_ff;
            rsp_oval_ff   <= oval_ff;
            rsp_drop_ff   <= drop_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      stat.kind       = kind_ff;
      stat.running    = run_ff == ST_RUN;
      stat.cw_zero    = cw_ff == '0;
      stat.dec_last   = dec_cnt_ff == 4'd15;
      stat.is_halt    = op_ff == OP_HALT;
      stat.np         = np_ff;
      stat.p_fault    = (raw >= NXW'(MEM_WORDS)) || (mode_k == MODE_BAD);
      stat.p_imm      = mode_k == MODE_IMM;
      stat.eff_bad    = eff_bad;
      stat.p_last     = k_ff == np_ff;
      stat.op_arith   = (op_ff == OP_ADD) || (op_ff == OP_LT) || (op_ff == OP_EQ);
      stat.op_mul     = op_ff == OP_MUL;
      stat.op_input   = op_ff == OP_IN;
      stat.fifo_empty = cnt_ff == '0;
      stat.jump_taken = ((op_ff == OP_JT) || (op_ff == OP_JF)) && jump_cond;
      stat.jump_bad   = b_ff >= MEM_LIM;
      stat.mul_last   = mul_cnt_ff == 2'd2;
      stat.ext_zero   = ext_ff == '0;
      stat.adv_last   = div_cnt_ff == DCW'(1);
      stat.clr_last   = clr_ff == AW'(MEM_WORDS - 1);
   end

   assign rsp_data      = {5'd0, rsp_drop_ff, rsp_oval_ff, rsp_status_ff};
   assign rsp_out_valid = rsp_ov_ff;
endmodule

@@ design/intcode_cpu_step.sv @@
// Intcode step machine. Each request item loads a word, pushes an input value,
// executes one instruction or clears the machine, and yields one response item
// with the run status, any output value and a FIFO overflow flag. Items are
// handled one at a time. A zero word faults at once, and a halt or a taken jump
// stops short of the divider; otherwise the machine fetches the word, makes up to
// five reads on the single-port word memory, runs a 16-step nibble-serial decimal
// decode, uses the shared 32x32 multiplier for a multiply, and passes through the
// bit-serial divider that wraps the PC at the touched extent.
// After reset, and on a clear item, a clearing pass writes zero to all MEM_WORDS
// words, one per cycle, and no item is taken meanwhile. A response held on a
// stalled output does not stop the next request from being taken.
module intcode_cpu_step #(
   parameter int MEM_WORDS = 4096,
   parameter int IN_DEPTH  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [icpu_pkg::REQ_DATA_W-1:0]  req_tdata,  // address[11:0], value[75:12], zero pad
   input  logic [1:0]                       req_tuser,  // kind[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [icpu_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // status[1:0], out_value[65:2],
                                                        // push_dropped[66], zero pad
   output logic                             rsp_tuser   // out_valid
);
   import icpu_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   icpu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   icpu_dpath #(.MEM_WORDS(MEM_WORDS), .IN_DEPTH(IN_DEPTH)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_kind      (req_tuser),
      .req_address   (req_tdata[ADDR_W-1:0]),
      .req_value     (req_tdata[ADDR_W+WORD_W-1:ADDR_W]),
      .rsp_data      (rsp_tdata),
      .rsp_out_valid (rsp_tuser)
   );
endmodule

@@ design/icpu_checker.sv @@
// Port-level checks for intcode_cpu_step, bound to the top level.
// Depends on icpu_pkg.
module icpu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [icpu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tuser
);
   import icpu_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // an output instruction leaves the machine running
   a_out_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == ST_RUN)
      else $error("output with non-running status");

   // no output value without an output instruction
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[65:2] == '0)
      else $error("stray output value");

   // a dropped push cannot carry an output
   a_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66] |-> !rsp_tuser)
      else $error("drop flag with output");
endmodule

bind intcode_cpu_step icpu_checker u_icpu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/intcode_cpu_step_test.sv @@
// Self-checking testbench for the intcode step machine (intcode_cpu_step).
// Predicts every response from its own model of the machine; uses icpu_pkg only.
`timescale 1ns / 1ps

module intcode_cpu_step_test;
   import icpu_pkg::*;

   localparam int MEMW      = 4096;
   localparam int FIFO_D    = 16;
   localparam int LIMIT_CYC = 3000000;

   typedef struct {
      run_state_type status;
      bit            out_valid;
      bit [63:0]     out_value;
      bit            dropped;
   } step_result_type;

   class step_scoreboard;
      bit [63:0]       word_mem [0:MEMW-1];
      bit [11:0]       pc;
      bit [63:0]       rel_base;
      run_state_type   state;
      int              extent;
      bit [63:0]       in_fifo [0:FIFO_D-1];
      int              fifo_head;
      int              fifo_cnt;
      step_result_type awaited[$];
      int              errors;

      function void clear_machine();
         foreach (word_mem[i]) word_mem[i] = '0;
         pc = '0; rel_base = '0; state = ST_RUN; extent = 0;
         fifo_head = 0; fifo_cnt = 0;
      endfunction

      function void store_word(int a, bit [63:0] v);
         if (a >= MEMW) return;
         word_mem[a] = v;
         if (a + 1 > extent) extent = a + 1;
      endfunction

      function bit resolve(int k, bit [63:0] mode, output int adr);
         int        raw;
         bit [63:0] v, u;
         adr = 0;
         raw = pc + k;
         if (raw >= MEMW) return 0;
         if (mode == MODE_IMM) begin
            adr = raw;
            return 1;
         end
         v = word_mem[raw];
         if (mode == MODE_POS) begin
            if (v >= MEMW) return 0;
            adr = int'(v);
            return 1;
         end
         if (mode == MODE_REL) begin
            if (v[63] && rel_base[63]) return 0;
            u = rel_base + v;
            if (u >= MEMW) return 0;
            adr = int'(u);
            return 1;
         end
         return 0;
      endfunction

      function void run_instr(output bit ov, output bit [63:0] oval);
         bit [63:0] cw, opc, a, b;
         bit [63:0] md [1:3];
         int        ad [1:3];
         int        np, len, nxt;
         ov = 0; oval = '0; a = '0; b = '0;
         ad[1] = 0; ad[2] = 0; ad[3] = 0;
         cw = word_mem[pc];
         if (cw == 0) begin
            state = ST_FAULT;
            return;
         end
         opc   = cw[63] ? 64'd0 : cw % 100;
         md[1] = (cw / 100) % 10;
         md[2] = (cw / 1000) % 10;
         md[3] = cw / DEC_DIV;
         if (opc == OP_HALT) begin
            state = ST_HALT;
            return;
         end
         case (opc)
            OP_ADD, OP_MUL, OP_LT, OP_EQ: np = 3;
            OP_JT, OP_JF:                 np = 2;
            OP_IN, OP_OUT, OP_ARB:        np = 1;
            default:                      np = 0;
         endcase
         for (int i = 1; i <= np; i++) begin
            if (!resolve(i, md[i], ad[i])) begin
               state = ST_FAULT;
               return;
            end
         end
         if (np >= 1) a = word_mem[ad[1]];
         if (np >= 2) b = word_mem[ad[2]];
         len = (np == 0) ? 2 : np + 1;
         case (opc)
            OP_ADD: store_word(ad[3], a + b);
            OP_MUL: store_word(ad[3], a * b);
            OP_LT:  store_word(ad[3], ($signed(a) < $signed(b)) ? 64'd1 : 64'd0);
            OP_EQ:  store_word(ad[3], (a == b) ? 64'd1 : 64'd0);
            OP_IN: begin
               if (fifo_cnt == 0) begin
                  state = ST_WAIT;
                  return;
               end
               store_word(ad[1], in_fifo[fifo_head]);
               fifo_head = (fifo_head + 1) % FIFO_D;
               fifo_cnt--;
            end
            OP_OUT: begin
               ov = 1;
               oval = a;
            end
            OP_JT, OP_JF: begin
               if ((opc == OP_JT) == (a != 0)) begin
                  if (b >= MEMW) state = ST_FAULT;
                  else pc = b[11:0];
                  return;
               end
            end
            OP_ARB: rel_base = rel_base + a;
            default: ;
         endcase
         nxt = pc + len;
         pc = (extent == 0) ? 12'd0 : 12'(nxt % extent);
      endfunction

      function void note_input(bit [1:0] kind, bit [11:0] addr, bit [63:0] val);
         step_result_type r;
         r.out_valid = 0; r.out_value = '0; r.dropped = 0;
         case (kind)
            KIND_LOAD: store_word(addr, val);
            KIND_PUSH: begin
               if (fifo_cnt >= FIFO_D) r.dropped = 1;
               else begin
                  in_fifo[(fifo_head + fifo_cnt) % FIFO_D] = val;
                  fifo_cnt++;
                  if (state == ST_WAIT) state = ST_RUN;
               end
            end
            KIND_EXEC: if (state == ST_RUN) run_instr(r.out_valid, r.out_value);
            default: clear_machine();
         endcase
         r.status = state;
         awaited.insert(awaited.size(), r);
      endfunction

      task report(string what, bit [63:0] got, bit [63:0] want);
         $display("mismatch on %s: got %h, expected %h", what, got, want);
         errors++;
      endtask

      task check(bit [1:0] st, bit ov, bit [63:0] oval, bit drop);
         step_result_type e;
         if (awaited.size() == 0) begin
            $display("response with nothing outstanding");
            errors++;
            return;
         end
         e = awaited[0];
         awaited.delete(0);
         if (st != e.status) report("status", st, e.status);
         if (ov != e.out_valid) report("out_valid", ov, e.out_valid);
         if (oval != e.out_value) report("out_value", oval, e.out_value);
         if (drop != e.dropped) report("push_dropped", drop, e.dropped);
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   step_scoreboard sb;
   int  burst_left;
   bit  hold_go;

   intcode_cpu_step u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= LIMIT_CYC) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // receiver: random stalls in phases, plus the long hold-off on request
   initial begin
      int phase_left;
      bit choppy;
      int hold_cycles;
      bit hold_done;
      phase_left = 0; choppy = 0;
      hold_cycles = 0; hold_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check(rsp_tdata[1:0], rsp_tuser, rsp_tdata[65:2], rsp_tdata[66]);
         if (hold_go && !hold_done) begin
            hold_done = 1;
            hold_cycles = 400;
         end
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 300);
            choppy = $urandom_range(0, 1);
         end
         phase_left--;
         if (reset) rsp_tready <= 1'b0;
         else if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (choppy) rsp_tready <= ($urandom_range(0, 2) != 0);
         else rsp_tready <= 1'b1;
      end
   end

   task send_item(bit [1:0] kind, bit [11:0] addr, bit [63:0] val);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'd0, val, addr};
      do @(posedge clock); while (!req_tready);
      sb.note_input(kind, addr, val);
      burst_left--;
   endtask

   // stop offering and wait until every response is back
   task drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.awaited.size() != 0);
   endtask

   function bit [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function bit [63:0] make_instr();
      bit [63:0] opc, m1, m2, m3;
      int        pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) return rand_word();
      if (pick < 6) opc = $urandom_range(10, 98);
      else if (pick < 9) opc = OP_HALT;
      else opc = $urandom_range(1, 9);
      m1 = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 9) : $urandom_range(0, 2);
      m2 = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 9) : $urandom_range(0, 2);
      m3 = ($urandom_range(0, 29) == 0) ? $urandom_range(3, 900) : $urandom_range(0, 2);
      return opc + 100 * m1 + 1000 * m2 + DEC_DIV * m3;
   endfunction

   function bit [63:0] make_operand(int n);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return rand_word();
      if (pick == 1) return -64'($urandom_range(1, 8));
      return $urandom_range(0, n + 8);
   endfunction

   // load a short random program and step through it, pushing inputs now and then
   task run_program();
      int n, steps, w;
      if ($urandom_range(0, 3) == 0) send_item(KIND_CLEAR, 0, 0);
      n = $urandom_range(6, 30);
      w = 0;
      while (w < n) begin
         send_item(KIND_LOAD, 12'(w), make_instr());
         w++;
         for (int j = 0; j < 3 && w < n; j++) begin
            send_item(KIND_LOAD, 12'(w), make_operand(n));
            w++;
         end
      end
      if ($urandom_range(0, 4) == 0) send_item(KIND_LOAD, 12'($urandom), rand_word());
      repeat ($urandom_range(0, 4)) send_item(KIND_PUSH, 0, make_operand(n));
      steps = $urandom_range(10, 30);
      repeat (steps) begin
         if ($urandom_range(0, 7) == 0) send_item(KIND_PUSH, 12'($urandom), rand_word());
         else send_item(KIND_EXEC, 12'($urandom), rand_word());
      end
   endtask

   initial begin
      sb = new();
      sb.errors = 0;
      sb.clear_machine();
      burst_left = 0;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = KIND_LOAD;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty memory faults, extremes, FIFO overflow, wait and wake
      send_item(KIND_EXEC, 0, 0);
      send_item(KIND_CLEAR, 12'hfff, '1);
      send_item(KIND_LOAD, 12'hfff, 64'h8000_0000_0000_0000);
      send_item(KIND_LOAD, 0, 64'h7fff_ffff_ffff_ffff);
      send_item(KIND_EXEC, 0, 0);
      send_item(KIND_CLEAR, 0, 0);
      for (int i = 0; i < 17; i++)
         send_item(KIND_PUSH, 0, (i == 0) ? 64'h8000_0000_0000_0000 :
                                 (i == 1) ? 64'h7fff_ffff_ffff_ffff : rand_word());
      send_item(KIND_LOAD, 0, OP_IN);
      send_item(KIND_LOAD, 1, 10);
      send_item(KIND_LOAD, 2, OP_OUT);
      send_item(KIND_LOAD, 3, 10);
      send_item(KIND_LOAD, 4, OP_HALT);
      repeat (4) send_item(KIND_EXEC, 0, 0);
      send_item(KIND_CLEAR, 0, 0);
      send_item(KIND_LOAD, 0, OP_IN);
      send_item(KIND_LOAD, 1, 10);
      send_item(KIND_LOAD, 2, 104);
      send_item(KIND_LOAD, 3, 64'hffff_ffff_ffff_ffff);
      repeat (2) send_item(KIND_EXEC, 0, 0);
      send_item(KIND_PUSH, 0, 7);
      repeat (2) send_item(KIND_EXEC, 0, 0);

      // sender stops until everything is back
      drain();
      for (int p = 0; p < 30; p++) begin
         if (p == 8) hold_go = 1;
         if (p == 16) drain();
         run_program();
      end

      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
